@@ sv/xkaip_pkg.sv @@
// ----------------------------------------------------------------------------
// xkaip_pkg
// Shared types and constants for the keyed archive index parser.
// ----------------------------------------------------------------------------
package xkaip_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned NAME_LEN_W     = 13;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned MAX_NAME_BYTES = 4096;
  localparam int unsigned START_POS      = 8;
  localparam int unsigned KEY_MUL        = 9;
  localparam int unsigned KEY_ADD        = 3;

  // Register indexes on the configuration port
  localparam logic REG_SIZE_BOUND = 1'b0;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_OFFSET,
    PH_SIZE,
    PH_EKEY,
    PH_NLEN,
    PH_NAME,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

endpackage

@@ sv/xkaip_ifs.sv @@
// ----------------------------------------------------------------------------
// xkaip_ifs
// Valid/ready channels for raw archive bytes and decoded index results.
// ----------------------------------------------------------------------------
interface xkaip_in_if import xkaip_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, data_byte, input ready);
  modport sink   (input valid, data_byte, output ready);
endinterface

interface xkaip_out_if import xkaip_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [WORD_W-1:0]     entry_offset;
  logic [WORD_W-1:0]     entry_size;
  logic [WORD_W-1:0]     entry_key;
  logic [NAME_LEN_W-1:0] name_length;
  logic [BYTE_W-1:0]     name_char;
  logic                  last;

  modport source (output valid, kind, entry_offset, entry_size, entry_key,
                  name_length, name_char, last, input ready);
  modport sink   (input valid, kind, entry_offset, entry_size, entry_key,
                  name_length, name_char, last, output ready);
endinterface

@@ sv/xkaip_apb_regs.sv @@
// ----------------------------------------------------------------------------
// xkaip_apb_regs
// APB register file holding the archive size used for the name bound check.
// ----------------------------------------------------------------------------
module xkaip_apb_regs import xkaip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WORD_W-1:0]     size_bound
);

  logic reg_sel;
  logic wr_en;

  // Word index lives above the byte lane bits
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_SIZE_BOUND) &&
                   (paddr[1:0] == 2'b00);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bound <= '0;
    end else if (wr_en && (paddr[APB_ADDR_W-1] == REG_SIZE_BOUND)) begin
      size_bound <= pwdata[WORD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = size_bound;
    end
  end

endmodule

@@ sv/xor_keyed_archive_index_parser.sv @@
// ----------------------------------------------------------------------------
// xor_keyed_archive_index_parser
// Decodes the XOR-keyed index table of an archive, one byte per transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                   Handshake
//  -------  ---------  ----------------------------------------  ---------
//  in_ch    sink       data_byte                                 valid/ready
//  out_ch   source     kind, entry_offset, entry_size,           valid/ready
//                      entry_key, name_length, name_char, last
//  apb      slave      archive size bound at byte address 0      psel/penable
//
//  One input byte is taken per clock while in_ch.ready is high. Each
//  accepted byte updates the parse state and, if it produces a result,
//  loads the output register in the same edge; it is the only stage.
//  in_ch.ready is high whenever the output register is empty or being taken,
//  so a full-rate stream runs at one byte per cycle while out_ch keeps up.
//  Reset (rst, synchronous) clears the parse state to wait for the key word
//  with stream position eight, and clears the archive size bound.
// ----------------------------------------------------------------------------
module xor_keyed_archive_index_parser import xkaip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  xkaip_in_if.sink              in_ch,
  xkaip_out_if.source           out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WORD_W-1:0] size_bound;

  xkaip_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .size_bound (size_bound)
  );

  // Parse state
  phase_t                phase, phase_next;
  logic [1:0]            word_byte_count, word_byte_count_next;
  logic [WORD_W-1:0]     word_gather, word_gather_next;
  logic [WORD_W-1:0]     table_key, table_key_next;
  logic [WORD_W-1:0]     held_offset, held_offset_next;
  logic [WORD_W-1:0]     held_size, held_size_next;
  logic [WORD_W-1:0]     held_entry_key, held_entry_key_next;
  logic [NAME_LEN_W-1:0] name_left, name_left_next;
  logic [1:0]            name_lane, name_lane_next;
  logic [WORD_W-1:0]     stream_position, stream_position_next;

  // Output register
  logic                  out_valid;
  kind_t                 out_kind;
  logic [WORD_W-1:0]     out_offset;
  logic [WORD_W-1:0]     out_size;
  logic [WORD_W-1:0]     out_ekey;
  logic [NAME_LEN_W-1:0] out_nlen;
  logic [BYTE_W-1:0]     out_char;
  logic                  out_last;

  // Result of the byte being accepted
  logic                  res_valid;
  kind_t                 res_kind;
  logic [WORD_W-1:0]     res_offset;
  logic [WORD_W-1:0]     res_size;
  logic [WORD_W-1:0]     res_ekey;
  logic [NAME_LEN_W-1:0] res_nlen;
  logic [BYTE_W-1:0]     res_char;
  logic                  res_last;

  logic                  accept;
  logic [WORD_W-1:0]     full_word;
  logic [WORD_W-1:0]     plain_word;
  logic [WORD_W-1:0]     pos_inc;
  logic [WORD_W-1:0]     room;
  logic [BYTE_W-1:0]     key_byte;
  logic [NAME_LEN_W-1:0] left_dec;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Word as it stands once this byte lands in its lane
  always_comb begin
    full_word = word_gather;
    case (word_byte_count)
      2'd0:    full_word[7:0]   = word_gather[7:0]   | in_ch.data_byte;
      2'd1:    full_word[15:8]  = word_gather[15:8]  | in_ch.data_byte;
      2'd2:    full_word[23:16] = word_gather[23:16] | in_ch.data_byte;
      default: full_word[31:24] = word_gather[31:24] | in_ch.data_byte;
    endcase
  end

  assign plain_word = full_word ^ table_key;

  // Position once the current byte is taken, held at the top of the range
  assign pos_inc = (stream_position != '1) ? (stream_position + WORD_W'(1)) :
                   stream_position;

  // Bytes left in the archive past the name length word, floored at zero
  assign room = (size_bound > pos_inc) ? (size_bound - pos_inc) : '0;

  always_comb begin
    case (name_lane)
      2'd0:    key_byte = table_key[7:0];
      2'd1:    key_byte = table_key[15:8];
      2'd2:    key_byte = table_key[23:16];
      default: key_byte = table_key[31:24];
    endcase
  end

  assign left_dec = name_left - NAME_LEN_W'(1);

  always_comb begin
    phase_next           = phase;
    word_byte_count_next = word_byte_count;
    word_gather_next     = word_gather;
    table_key_next       = table_key;
    held_offset_next     = held_offset;
    held_size_next       = held_size;
    held_entry_key_next  = held_entry_key;
    name_left_next       = name_left;
    name_lane_next       = name_lane;
    stream_position_next = stream_position;

    res_valid  = 1'b0;
    res_kind   = KIND_HEADER;
    res_offset = '0;
    res_size   = '0;
    res_ekey   = '0;
    res_nlen   = '0;
    res_char   = '0;
    res_last   = 1'b0;

    if (phase != PH_DONE) begin
      // Position saturates at the top of the range
      if (stream_position != '1) begin
        stream_position_next = stream_position + WORD_W'(1);
      end
    end

    if (accept && (phase != PH_DONE)) begin
      if (phase == PH_NAME) begin
        // Name bytes bypass word gathering; key byte rotates per byte
        name_lane_next = name_lane + 2'd1;
        name_left_next = left_dec;
        res_valid      = 1'b1;
        res_kind       = KIND_NAME;
        res_char       = in_ch.data_byte ^ key_byte;
        res_last       = (left_dec == '0);
        if (left_dec == '0) begin
          phase_next = PH_OFFSET;
        end
      end else begin
        word_byte_count_next = word_byte_count + 2'd1;
        if (word_byte_count != 2'd3) begin
          word_gather_next = full_word;
        end else begin
          word_gather_next = '0;
          case (phase)
            PH_KEY: begin
              // K = W*9 + 3, as shift and add
              table_key_next = (full_word << 3) + full_word + WORD_W'(KEY_ADD);
              phase_next     = PH_OFFSET;
            end
            PH_OFFSET: begin
              held_offset_next = plain_word;
              if (plain_word == '0) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res_kind   = KIND_END;
              end else begin
                phase_next = PH_SIZE;
              end
            end
            PH_SIZE: begin
              held_size_next = plain_word;
              phase_next     = PH_EKEY;
            end
            PH_EKEY: begin
              held_entry_key_next = plain_word;
              phase_next          = PH_NLEN;
            end
            default: begin
              res_valid = 1'b1;
              if ((plain_word > WORD_W'(MAX_NAME_BYTES)) || (plain_word > room)) begin
                phase_next = PH_DONE;
                res_kind   = KIND_ERROR;
              end else begin
                name_left_next = plain_word[NAME_LEN_W-1:0];
                name_lane_next = 2'd0;
                phase_next     = (plain_word == '0) ? PH_OFFSET : PH_NAME;
                res_kind       = KIND_HEADER;
                res_offset     = held_offset;
                res_size       = held_size;
                res_ekey       = held_entry_key;
                res_nlen       = plain_word[NAME_LEN_W-1:0];
                res_last       = (plain_word == '0);
              end
            end
          endcase
        end
      end
    end

    // Position only advances on an accepted byte
    if (!accept) begin
      stream_position_next = stream_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_KEY;
      word_byte_count <= '0;
      word_gather     <= '0;
      table_key       <= '0;
      held_offset     <= '0;
      held_size       <= '0;
      held_entry_key  <= '0;
      name_left       <= '0;
      name_lane       <= '0;
      stream_position <= WORD_W'(START_POS);
    end else begin
      phase           <= phase_next;
      word_byte_count <= word_byte_count_next;
      word_gather     <= word_gather_next;
      table_key       <= table_key_next;
      held_offset     <= held_offset_next;
      held_size       <= held_size_next;
      held_entry_key  <= held_entry_key_next;
      name_left       <= name_left_next;
      name_lane       <= name_lane_next;
      stream_position <= stream_position_next;
    end
  end

  // Output register: load on a new result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind   <= res_kind;
      out_offset <= res_offset;
      out_size   <= res_size;
      out_ekey   <= res_ekey;
      out_nlen   <= res_nlen;
      out_char   <= res_char;
      out_last   <= res_last;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_kind;
  assign out_ch.entry_offset = out_offset;
  assign out_ch.entry_size   = out_size;
  assign out_ch.entry_key    = out_ekey;
  assign out_ch.name_length  = out_nlen;
  assign out_ch.name_char    = out_char;
  assign out_ch.last         = out_last;

endmodule

@@ tb/sv/xor_keyed_archive_index_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_keyed_archive_index_parser_test
// Streams one keyed archive index through the parser and checks each decoded
// record. The stream runs in three stretches with different idle patterns.
// Between drained sections of the stream the archive size register is rewritten while the parser
// is idle. The stream closes with an end marker or a rejected name length.
// ----------------------------------------------------------------------------
module xor_keyed_archive_index_parser_test;
  import xkaip_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_STALL  = 200;
  localparam int unsigned PRINT_CAP   = 40;
  localparam logic [APB_ADDR_W-1:0] SIZE_ADDR = APB_ADDR_W'(REG_SIZE_BOUND) << 2;

  // One decoded record as the parser should present it
  typedef struct {
    kind_t                 kind;
    logic [WORD_W-1:0]     body_offset;
    logic [WORD_W-1:0]     body_size;
    logic [WORD_W-1:0]     ekey;
    logic [NAME_LEN_W-1:0] nlen;
    logic [BYTE_W-1:0]     ch;
    logic                  last;
  } index_rec_t;

  logic clk = 1'b0;
  logic rst;

  xkaip_in_if  in_ch();
  xkaip_out_if out_ch();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  xor_keyed_archive_index_parser uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] archive_bytes[$];   // raw bytes waiting for the driver
  index_rec_t        pending_records[$]; // decoded records not yet seen
  int unsigned       bytes_queued  = 0;
  int unsigned       bytes_taken   = 0;
  int unsigned       fail_count    = 0;
  int unsigned       cycle_count   = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  bit                stall_req     = 1'b0;
  int unsigned       stall_cycles  = 0;

  // --------------------------------------------------------------------------
  // Index decoder: own copy of the parse state, advanced on every accepted
  // byte. The parser leaves reset only once, so these start at reset values.
  // --------------------------------------------------------------------------
  phase_t                ph         = PH_KEY;
  logic [1:0]            byte_cnt   = '0;
  logic [WORD_W-1:0]     gather     = '0;
  logic [WORD_W-1:0]     tkey       = '0;
  logic [WORD_W-1:0]     h_off      = '0;
  logic [WORD_W-1:0]     h_size     = '0;
  logic [WORD_W-1:0]     h_ekey     = '0;
  logic [NAME_LEN_W-1:0] left       = '0;
  logic [1:0]            lane       = '0;
  logic [WORD_W-1:0]     pos        = START_POS;
  logic [WORD_W-1:0]     bound_size = '0;  // archive size as last written

  // Append a record to the tail of the expected list
  function automatic void add_record(input index_rec_t rec);
    pending_records.insert(pending_records.size(), rec);
  endfunction

  function automatic void parse_byte(input logic [BYTE_W-1:0] raw);
    index_rec_t        rec;
    logic [WORD_W-1:0] dword;
    logic [WORD_W-1:0] nlen;
    logic [WORD_W-1:0] room;
    logic [BYTE_W-1:0] key_lane;
    rec.kind        = KIND_HEADER;
    rec.body_offset = '0;
    rec.body_size   = '0;
    rec.ekey        = '0;
    rec.nlen        = '0;
    rec.ch          = '0;
    rec.last        = 1'b0;
    // Past end or error everything is dropped
    if (ph == PH_DONE) return;
    if (pos != 32'hFFFF_FFFF) pos = pos + 1;
    if (ph == PH_NAME) begin
      key_lane = 8'(tkey >> (8 * lane));
      lane     = lane + 1'b1;
      left     = left - 1'b1;
      rec.kind = KIND_NAME;
      rec.ch   = raw ^ key_lane;
      rec.last = (left == 0);
      if (left == 0) ph = PH_OFFSET;
      add_record(rec);
      return;
    end
    // Gather little-endian dwords; partial dwords give nothing
    gather   = gather | (32'(raw) << (8 * byte_cnt));
    byte_cnt = byte_cnt + 1'b1;
    if (byte_cnt != 0) return;
    dword  = gather;
    gather = '0;
    case (ph)
      PH_KEY: begin
        tkey = dword * KEY_MUL + KEY_ADD;
        ph   = PH_OFFSET;
      end
      PH_OFFSET: begin
        h_off = dword ^ tkey;
        if (h_off == 0) begin
          ph       = PH_DONE;
          rec.kind = KIND_END;
          add_record(rec);
        end else begin
          ph = PH_SIZE;
        end
      end
      PH_SIZE: begin
        h_size = dword ^ tkey;
        ph     = PH_EKEY;
      end
      PH_EKEY: begin
        h_ekey = dword ^ tkey;
        ph     = PH_NLEN;
      end
      default: begin
        nlen = dword ^ tkey;
        room = (bound_size > pos) ? bound_size - pos : '0;
        if (nlen > MAX_NAME_BYTES || nlen > room) begin
          ph       = PH_DONE;
          rec.kind = KIND_ERROR;
        end else begin
          left            = nlen[NAME_LEN_W-1:0];
          lane            = '0;
          ph              = (nlen == 0) ? PH_OFFSET : PH_NAME;
          rec.body_offset = h_off;
          rec.body_size   = h_size;
          rec.ekey        = h_ekey;
          rec.nlen        = nlen[NAME_LEN_W-1:0];
          rec.last        = (nlen == 0);
        end
        add_record(rec);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stream builder: encodes table entries with the key it chose, tracking the
  // absolute position so that name lengths can be placed against the bound.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] gen_key = '0;
  logic [WORD_W-1:0] gen_pos = START_POS;

  function automatic void queue_byte(input logic [BYTE_W-1:0] b);
    archive_bytes.insert(archive_bytes.size(), b);
    bytes_queued++;
    gen_pos = gen_pos + 1;
  endfunction

  function automatic void queue_dword(input logic [WORD_W-1:0] v);
    for (int i = 0; i < 4; i++) queue_byte(v[8*i +: 8]);
  endfunction

  // Names longer than the cap are never reached, so skip their bytes
  function automatic void queue_entry(input logic [WORD_W-1:0] off, input logic [WORD_W-1:0] sz,
                                      input logic [WORD_W-1:0] ek, input logic [WORD_W-1:0] nl,
                                      input bit alt);
    queue_dword(off ^ gen_key);
    queue_dword(sz ^ gen_key);
    queue_dword(ek ^ gen_key);
    queue_dword(nl ^ gen_key);
    if (nl <= MAX_NAME_BYTES) begin
      for (int i = 0; i < nl; i++) queue_byte(alt ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom));
    end
  endfunction

  // Mostly short names, now and then a longer one
  function automatic void queue_random_entry();
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] nl;
    off = $urandom;
    if (off == 0) off = 1;
    if ($urandom_range(9) == 0) nl = $urandom_range(64, 13);
    else nl = $urandom_range(12, 0);
    queue_entry(off, $urandom, $urandom, nl, 1'b0);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes: setup cycle, then access cycle
  // --------------------------------------------------------------------------
  task automatic write_size_bound(input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    bound_size = value;
  endtask

  // Hold until every queued byte is taken and every record has come out,
  // then let the one-stage pipe settle
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || pending_records.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next raw byte, hold it until taken, idle at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      parse_byte(in_ch.data_byte);
      bytes_taken++;
    end
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (archive_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= archive_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each taken record with the oldest decoded one
  // --------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [WORD_W-1:0] exp_v,
                                      input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      if (fail_count < PRINT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : take_results
    index_rec_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_records.size() == 0) begin
        if (fail_count < PRINT_CAP)
          $display("%0t: record with none expected, expected nothing, actual kind %0d",
                   $time, out_ch.kind);
        fail_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("entry_offset", want.body_offset, out_ch.entry_offset);
        check_field("entry_size", want.body_size, out_ch.entry_size);
        check_field("entry_key", want.ekey, out_ch.entry_key);
        check_field("name_length", want.nlen, out_ch.name_length);
        check_field("name_char", want.ch, out_ch.name_char);
        check_field("last", want.last, out_ch.last);
      end
    end
    // Once asked, hold ready low for a long stretch so the parser backs up
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_req && stall_cycles < LONG_STALL) begin
      stall_cycles <= stall_cycles + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("xor_keyed_archive_index_parser_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [WORD_W-1:0] nl_fit;
    int unsigned       ending;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Stretch one: mostly busy sender, mostly stalled receiver
    send_idle_pct = 29;
    recv_idle_pct = 88;

    // Zero archive size: only an empty name fits
    write_size_bound(32'h0000_0000);
    queue_dword(32'hFFFF_FFFF);
    gen_key = 32'hFFFF_FFFF * KEY_MUL + KEY_ADD;
    queue_entry(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0);
    wait_drained();

    // Widest bound; short name with all-zero and all-one bytes, lane wrap
    write_size_bound(32'hFFFF_FFFF);
    queue_entry(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 5, 1'b1);
    while (gen_pos < 160) queue_random_entry();
    wait_drained();

    // Stretch two: mostly idle sender, busy receiver
    send_idle_pct = 88;
    recv_idle_pct = 29;

    // Bound set so the next name ends exactly at the archive end
    nl_fit = $urandom_range(8, 1);
    write_size_bound(gen_pos + 16 + nl_fit);
    queue_entry($urandom_range(32'hFFFF, 1), $urandom, $urandom, nl_fit, 1'b0);
    wait_drained();
    write_size_bound({1'b1, 31'($urandom)});
    while (gen_pos < 320) queue_random_entry();
    wait_drained();

    // Stretch three: no idling, one long receiver hold-off at the start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req     = 1'b1;
    while (gen_pos < 420) queue_random_entry();
    wait_drained();

    // Close the table one of three ways, then trail bytes that are dropped
    ending = $urandom_range(2);
    if (ending == 0) begin
      queue_dword(gen_key);
    end else if (ending == 1) begin
      queue_entry($urandom | 32'h1, $urandom, $urandom,
                  $urandom_range(1) ? MAX_NAME_BYTES + 1 : 32'hFFFF_FFFF, 1'b0);
    end else begin
      nl_fit = $urandom_range(40, 1);
      write_size_bound(gen_pos + 16 + nl_fit - 1);
      queue_entry($urandom | 32'h1, $urandom, $urandom, nl_fit, 1'b0);
    end
    repeat (8) queue_byte($urandom);
    wait_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_records.size() == 0) begin
      $display("xor_keyed_archive_index_parser_test OK");
    end else begin
      $display("xor_keyed_archive_index_parser_test NOT OK");
    end
    $finish;
  end

endmodule
